### hdl/hbi_pkg.sv
// ----------------------------------------------------------------------------
// hbi_pkg
// Shared constants and register codes of the half-band x2 interpolator.
// ----------------------------------------------------------------------------
package hbi_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF = 16;

  localparam int DELAY_DEPTH = 14;
  localparam int NUM_SYM     = DELAY_DEPTH / 2;
  localparam int NUM_REGS    = NUM_SYM + 1;
  localparam int SYM_IDX_W   = $clog2(NUM_SYM);
  localparam int FRAC_SHIFT  = 15;
  localparam int CFG_IDX_W   = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_0      = 4'd0,
    REG_COEF_2      = 4'd1,
    REG_COEF_4      = 4'd2,
    REG_COEF_6      = 4'd3,
    REG_COEF_8      = 4'd4,
    REG_COEF_10     = 4'd5,
    REG_COEF_12     = 4'd6,
    REG_COEF_CENTER = 4'd7
  } cfg_reg_e;

  localparam logic signed [31:0] COEF_RESET [NUM_REGS] = '{
    32'sd33, -32'sd158, 32'sd491, -32'sd1214,
    32'sd2674, -32'sd5942, 32'sd20503, 32'sd32767
  };

endpackage

### hdl/hbi_front.sv
// ----------------------------------------------------------------------------
// hbi_front
// Accepts input items, shifts the delay line and forms the symmetric
// pre-sums and the centre sample for the back end.
// ----------------------------------------------------------------------------
module hbi_front import hbi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int PW = DATA_WIDTH + 1,
  localparam int EW = 2 * NUM_SYM * PW + 2 * DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] in_re_i,
  input  logic signed [DATA_WIDTH-1:0] in_im_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic [EW-1:0]                q_data_o
);

  logic signed [DATA_WIDTH-1:0] dl_re_q [DELAY_DEPTH];
  logic signed [DATA_WIDTH-1:0] dl_im_q [DELAY_DEPTH];
  logic signed [DATA_WIDTH-1:0] nxt_re [DELAY_DEPTH];
  logic signed [DATA_WIDTH-1:0] nxt_im [DELAY_DEPTH];
  logic                         accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    nxt_re[0] = in_re_i;
    nxt_im[0] = in_im_i;
    for (int k = 1; k < DELAY_DEPTH; k++) begin
      nxt_re[k] = dl_re_q[k-1];
      nxt_im[k] = dl_im_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        dl_re_q[k] <= '0;
        dl_im_q[k] <= '0;
      end
    end else if (accept) begin
      for (int k = 0; k < DELAY_DEPTH; k++) begin
        dl_re_q[k] <= nxt_re[k];
        dl_im_q[k] <= nxt_im[k];
      end
    end
  end

  // oldest pair goes with the outermost tap
  always_comb begin
    for (int k = 0; k < NUM_SYM; k++) begin
      q_data_o[k*PW +: PW] =
        PW'(nxt_re[DELAY_DEPTH-1-k]) + PW'(nxt_re[k]);
      q_data_o[(NUM_SYM+k)*PW +: PW] =
        PW'(nxt_im[DELAY_DEPTH-1-k]) + PW'(nxt_im[k]);
    end
    q_data_o[2*NUM_SYM*PW +: DATA_WIDTH]              = nxt_re[NUM_SYM-1];
    q_data_o[2*NUM_SYM*PW+DATA_WIDTH +: DATA_WIDTH]   = nxt_im[NUM_SYM-1];
  end

endmodule

### hdl/hbi_queue.sv
// ----------------------------------------------------------------------------
// hbi_queue
// Short FIFO that decouples the front end from the filter back end.
// ----------------------------------------------------------------------------
module hbi_queue import hbi_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

### hdl/hbi_back.sv
// ----------------------------------------------------------------------------
// hbi_back
// Coefficient registers, multiply and sum pipeline, rounding and saturation,
// and a two-slot output buffer for the even and centre phase results.
// ----------------------------------------------------------------------------
module hbi_back import hbi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF,
  localparam int PW = DATA_WIDTH + 1,
  localparam int EW = 2 * NUM_SYM * PW + 2 * DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  logic [EW-1:0]                q_data_i,
  output logic                         q_pop_o,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [COEF_WIDTH-1:0]        cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] out_re_o,
  output logic signed [DATA_WIDTH-1:0] out_im_o,
  output logic                         out_last_o
);

  localparam int PRW = PW + COEF_WIDTH;
  localparam int CPW = DATA_WIDTH + COEF_WIDTH;
  localparam int AW  = PRW + 3;
  localparam int NPS = (NUM_SYM + 1) / 2;
  localparam int CTR_OFS = 2 * NUM_SYM * PW;
  localparam logic signed [AW-1:0] SAT_MAX =
    {{(AW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN = ~SAT_MAX;

  function automatic logic [DATA_WIDTH-1:0] finish(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] sh;
    sh = acc >>> FRAC_SHIFT;
    if (sh > SAT_MAX) begin
      return SAT_MAX[DATA_WIDTH-1:0];
    end else if (sh < SAT_MIN) begin
      return SAT_MIN[DATA_WIDTH-1:0];
    end
    return sh[DATA_WIDTH-1:0];
  endfunction

  logic signed [COEF_WIDTH-1:0] coef_sym_q [NUM_SYM];
  logic signed [COEF_WIDTH-1:0] coef_ctr_q;

  logic                  adv;
  logic                  p_v_q, a1_v_q, a2_v_q;
  logic signed [PRW-1:0] prod_re_q [NUM_SYM];
  logic signed [PRW-1:0] prod_im_q [NUM_SYM];
  logic signed [CPW-1:0] cp_re_q, cp_im_q;
  logic signed [AW-1:0]  ext_re [2*NPS];
  logic signed [AW-1:0]  ext_im [2*NPS];
  logic signed [AW-1:0]  ps_re_q [NPS];
  logic signed [AW-1:0]  ps_im_q [NPS];
  logic signed [CPW-1:0] cp_re_a1_q, cp_im_a1_q;
  logic signed [AW-1:0]  sum_re_d, sum_im_d;
  logic signed [AW-1:0]  sum_re_q, sum_im_q;
  logic signed [CPW-1:0] cp_re_a2_q, cp_im_a2_q;
  logic [DATA_WIDTH-1:0] res_re_q [2];
  logic [DATA_WIDTH-1:0] res_im_q [2];
  logic [1:0]            cnt_q;
  logic                  take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SYM; i++) begin
        coef_sym_q[i] <= COEF_RESET[i][COEF_WIDTH-1:0];
      end
      coef_ctr_q <= COEF_RESET[NUM_SYM][COEF_WIDTH-1:0];
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_COEF_CENTER) begin
        coef_ctr_q <= cfg_data_i;
      end else if (cfg_index_i < REG_COEF_CENTER) begin
        coef_sym_q[cfg_index_i[SYM_IDX_W-1:0]] <= cfg_data_i;
      end
    end
  end

  assign take    = out_valid_o && !out_stall_i;
  assign adv     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  assign q_pop_o = adv && !q_empty_i;

  genvar g;
  for (g = 0; g < 2*NPS; g++) begin : g_ext
    if (g < NUM_SYM) begin : g_prod
      assign ext_re[g] = AW'(prod_re_q[g]);
      assign ext_im[g] = AW'(prod_im_q[g]);
    end else begin : g_pad
      assign ext_re[g] = '0;
      assign ext_im[g] = '0;
    end
  end

  always_comb begin
    sum_re_d = '0;
    sum_im_d = '0;
    for (int j = 0; j < NPS; j++) begin
      sum_re_d = sum_re_d + ps_re_q[j];
      sum_im_d = sum_im_d + ps_im_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NUM_SYM; k++) begin
        prod_re_q[k] <= $signed(q_data_i[k*PW +: PW]) * coef_sym_q[k];
        prod_im_q[k] <= $signed(q_data_i[(NUM_SYM+k)*PW +: PW]) * coef_sym_q[k];
      end
      cp_re_q <= $signed(q_data_i[CTR_OFS +: DATA_WIDTH]) * coef_ctr_q;
      cp_im_q <= $signed(q_data_i[CTR_OFS+DATA_WIDTH +: DATA_WIDTH]) * coef_ctr_q;
      for (int j = 0; j < NPS; j++) begin
        ps_re_q[j] <= ext_re[2*j] + ext_re[2*j+1];
        ps_im_q[j] <= ext_im[2*j] + ext_im[2*j+1];
      end
      cp_re_a1_q <= cp_re_q;
      cp_im_a1_q <= cp_im_q;
      sum_re_q   <= sum_re_d;
      sum_im_q   <= sum_im_d;
      cp_re_a2_q <= cp_re_a1_q;
      cp_im_a2_q <= cp_im_a1_q;
      res_re_q[0] <= finish(sum_re_q);
      res_im_q[0] <= finish(sum_im_q);
      res_re_q[1] <= finish(AW'(cp_re_a2_q));
      res_im_q[1] <= finish(AW'(cp_im_a2_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q  <= 1'b0;
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (adv) begin
        p_v_q  <= q_pop_o;
        a1_v_q <= p_v_q;
        a2_v_q <= a1_v_q;
      end
      if (adv && a2_v_q) begin
        cnt_q <= 2'd2;
      end else if (take) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_last_o  = (cnt_q == 2'd1);
  assign out_re_o    = out_last_o ? res_re_q[1] : res_re_q[0];
  assign out_im_o    = out_last_o ? res_im_q[1] : res_im_q[0];

endmodule

### hdl/halfband_interpolator_x2_unit.sv
// ----------------------------------------------------------------------------
// halfband_interpolator_x2_unit
// Complex half-band interpolator by two, 27 symmetric taps, Q15 coefficients.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       sink       in_valid_i / in_stall_o   in_re_i, in_im_i
//  out      source     out_valid_o / out_stall_i out_re_o, out_im_o, out_last_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  Each item yields two results, even phase first, so the output port sets
//  the rate; input items are accepted while the two-entry queue has room.
//  The first result passes the queue, then the multiply, two add stages and
//  the output buffer, each of them registered.
//  Reset clears the delay line, queue, pipeline valids and loads the default
//  coefficients. Either side may stall independently.
// ----------------------------------------------------------------------------
module halfband_interpolator_x2_unit import hbi_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] in_re_i,
  input  logic signed [DATA_WIDTH-1:0] in_im_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] out_re_o,
  output logic signed [DATA_WIDTH-1:0] out_im_o,
  output logic                         out_last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [COEF_WIDTH-1:0]        cfg_data_i
);

  localparam int PW = DATA_WIDTH + 1;
  localparam int EW = 2 * NUM_SYM * PW + 2 * DATA_WIDTH;

  logic          q_full, q_empty, q_push, q_pop;
  logic [EW-1:0] q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  hbi_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_re_i   (in_re_i),
    .in_im_i   (in_im_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  hbi_queue #(
    .WIDTH(EW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  hbi_back #(
    .DATA_WIDTH(DATA_WIDTH),
    .COEF_WIDTH(COEF_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_re_o   (out_re_o),
    .out_im_o   (out_im_o),
    .out_last_o (out_last_o)
  );

endmodule
